@@ rtl/core/reward_weighted_next_hop_table_macros.svh @@
// assertion macros for the reward weighted next hop table
// used by the top level, needs nothing else
`ifndef REWARD_WEIGHTED_NEXT_HOP_TABLE_MACROS_SVH
`define REWARD_WEIGHTED_NEXT_HOP_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define RWNH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RWNH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rwnh_pkg.sv @@
// shared constants, types and helpers of the next hop table
// no dependencies
`default_nettype none

package rwnh_pkg;

  // table geometry and weight format
  localparam int NODE_COUNT  = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int REWARD_W    = 16;
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int PAIR_W      = 2 * NODE_W;
  localparam int ADDR_W      = 3 * NODE_W;
  localparam int CNT_W       = $clog2(NODE_COUNT + 1);
  localparam int ALU_W       = WEIGHT_BITS + 1;

  // weight range as wide signed constants
  localparam logic signed [32:0] W_MAX_WIDE = (33'sd1 <<< (WEIGHT_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] W_MIN_WIDE = -(33'sd1 <<< (WEIGHT_BITS - 1));

  // item codes
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_SELECT = 1'b1;

  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef logic [NODE_COUNT-1:0]         vrow_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SEL,
    ST_PUSH
  } state_e;

  // memory port requests from the sequencer
  typedef struct packed {
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    weight_t           w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic              v_we;
    logic [PAIR_W-1:0] v_waddr;
    vrow_t             v_wdata;
    logic [PAIR_W-1:0] v_raddr;
  } store_req_t;

  // clamp a 16 bit reward into the weight range
  function automatic weight_t sat_reward(logic signed [REWARD_W-1:0] r);
    logic signed [32:0] t;
    t = 33'(r);
    if (t > W_MAX_WIDE) begin
      return W_MAX_WIDE[WEIGHT_BITS-1:0];
    end else if (t < W_MIN_WIDE) begin
      return W_MIN_WIDE[WEIGHT_BITS-1:0];
    end
    return t[WEIGHT_BITS-1:0];
  endfunction

  // weight to the 16 bit result field, sign extended or truncated
  function automatic logic [15:0] to_out16(weight_t w);
    logic signed [32:0] t;
    t = 33'(w);
    return t[15:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/rwnh_alu.sv @@
// shared add / subtract unit, one extra bit of headroom
// depends on rwnh_pkg
`default_nettype none

module rwnh_alu
  import rwnh_pkg::*;
(
  input  weight_t          a_i,
  input  weight_t          b_i,
  input  logic             sub_i,
  output logic [ALU_W-1:0] res_o
);

  logic [ALU_W-1:0] a_ext;
  logic [ALU_W-1:0] b_ext;

  // sign extend, invert b and carry in for subtraction
  assign a_ext = ALU_W'(a_i);
  assign b_ext = ALU_W'(b_i) ^ {ALU_W{sub_i}};
  assign res_o = a_ext + b_ext + ALU_W'(sub_i);

endmodule

`default_nettype wire

@@ rtl/core/rwnh_store.sv @@
// weight memory and valid-row memory, one write and one registered read each
// depends on rwnh_pkg
`default_nettype none

module rwnh_store
  import rwnh_pkg::*;
(
  input  logic       clk_i,
  input  store_req_t req_i,
  output weight_t    w_rdata_o,
  output vrow_t      v_rdata_o
);

  weight_t wmem [2**ADDR_W];
  vrow_t   vmem [2**PAIR_W];
  weight_t w_rdata_q;
  vrow_t   v_rdata_q;

  // weights, one entry per source, destination and hop
  always_ff @(posedge clk_i) begin
    if (req_i.w_we) begin
      wmem[req_i.w_waddr] <= req_i.w_wdata;
    end
    w_rdata_q <= wmem[req_i.w_raddr];
  end

  // valid bits, one row of hops per source and destination
  always_ff @(posedge clk_i) begin
    if (req_i.v_we) begin
      vmem[req_i.v_waddr] <= req_i.v_wdata;
    end
    v_rdata_q <= vmem[req_i.v_raddr];
  end

  assign w_rdata_o = w_rdata_q;
  assign v_rdata_o = v_rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/reward_weighted_next_hop_table.sv @@
// update: an accepted beat passes ST_UPD_RD, ST_UPD_WR and ST_PUSH before the next beat is taken
// select: one weight read per cycle over NODE_COUNT hops in ST_SEL, then ST_PUSH, before the
//   next beat is taken; ST_PUSH waits until the result register is free
// the weight memory read port and the shared adder set these steps
// reset: a clearing pass zeroes all 2**(2*NODE_W) valid rows, no input
//   beat is taken until it ends
`default_nettype none

`include "reward_weighted_next_hop_table_macros.svh"

module reward_weighted_next_hop_table
  import rwnh_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic [NODE_W-1:0]          src_node_i,
  input  logic [NODE_W-1:0]          dst_node_i,
  input  logic [NODE_W-1:0]          next_hop_i,
  input  logic signed [REWARD_W-1:0] reward_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [NODE_W-1:0]          chosen_hop_o,
  output logic                       found_o,
  output logic signed [15:0]         best_weight_o
);

  state_e             state_q, state_d;
  logic [PAIR_W-1:0]  clr_q, clr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               cmp_v_q, cmp_v_d;
  logic               out_valid_q, out_valid_d;

  logic               mode_q, mode_d;
  logic [NODE_W-1:0]  src_q, src_d;
  logic [NODE_W-1:0]  dst_q, dst_d;
  logic [NODE_W-1:0]  hop_q, hop_d;
  weight_t            rew_q, rew_d;
  logic               ok_q, ok_d;
  logic [NODE_W-1:0]  cmp_hop_q, cmp_hop_d;
  weight_t            best_q, best_d;
  logic [NODE_W-1:0]  chosen_q, chosen_d;
  logic               found_q, found_d;
  logic [NODE_W-1:0]  out_hop_q, out_hop_d;
  logic               out_found_q, out_found_d;
  logic [15:0]        out_weight_q, out_weight_d;

  store_req_t         req;
  weight_t            w_rdata;
  vrow_t              v_rdata;
  weight_t            alu_b;
  logic               alu_sub;
  logic [ALU_W-1:0]   alu_res;
  weight_t            new_w;
  logic               pair_ok;
  logic               hop_ok;

  rwnh_store u_store (
    .clk_i     (clk_i),
    .req_i     (req),
    .w_rdata_o (w_rdata),
    .v_rdata_o (v_rdata)
  );

  rwnh_alu u_alu (
    .a_i   (w_rdata),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res)
  );

  // range of the incoming node indices
  assign pair_ok = (int'(src_node_i) < NODE_COUNT) && (int'(dst_node_i) < NODE_COUNT);
  assign hop_ok  = int'(next_hop_i) < NODE_COUNT;

  // average of stored weight and reward, or the reward on a fresh entry
  assign new_w = v_rdata[hop_q] ? weight_t'(alu_res[ALU_W-1:1]) : rew_q;

  // sequencer: next state, memory requests and result
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cnt_d        = cnt_q;
    cmp_v_d      = cmp_v_q;
    out_valid_d  = out_valid_q;
    mode_d       = mode_q;
    src_d        = src_q;
    dst_d        = dst_q;
    hop_d        = hop_q;
    rew_d        = rew_q;
    ok_d         = ok_q;
    cmp_hop_d    = cmp_hop_q;
    best_d       = best_q;
    chosen_d     = chosen_q;
    found_d      = found_q;
    out_hop_d    = out_hop_q;
    out_found_d  = out_found_q;
    out_weight_d = out_weight_q;
    in_ready_o   = 1'b0;
    alu_b        = rew_q;
    alu_sub      = 1'b0;

    req         = '0;
    req.w_raddr = {src_q, dst_q, hop_q};
    req.v_raddr = {src_q, dst_q};

    // result beat taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        req.v_we    = 1'b1;
        req.v_waddr = clr_q;
        req.v_wdata = '0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d   = mode_i;
          src_d    = src_node_i;
          dst_d    = dst_node_i;
          hop_d    = next_hop_i;
          rew_d    = sat_reward(reward_i);
          cnt_d    = '0;
          cmp_v_d  = 1'b0;
          best_d   = '0;
          chosen_d = '0;
          found_d  = 1'b0;
          if (mode_i == MODE_SELECT) begin
            ok_d    = pair_ok;
            state_d = ST_SEL;
          end else begin
            ok_d    = pair_ok && hop_ok;
            state_d = ST_UPD_RD;
          end
        end
      end

      ST_UPD_RD: begin
        state_d = ST_UPD_WR;
      end

      ST_UPD_WR: begin
        chosen_d = hop_q;
        if (ok_q) begin
          req.w_we    = 1'b1;
          req.w_waddr = {src_q, dst_q, hop_q};
          req.w_wdata = new_w;
          req.v_we    = 1'b1;
          req.v_waddr = {src_q, dst_q};
          req.v_wdata = v_rdata | (vrow_t'(1) << hop_q);
          best_d      = new_w;
          found_d     = 1'b1;
        end else begin
          best_d  = '0;
          found_d = 1'b0;
        end
        state_d = ST_PUSH;
      end

      ST_SEL: begin
        // read hop cnt_q, compare the hop read in the previous cycle
        req.w_raddr = {src_q, dst_q, cnt_q[NODE_W-1:0]};
        alu_b       = best_q;
        alu_sub     = 1'b1;
        cmp_v_d     = cnt_q < CNT_W'(NODE_COUNT);
        cmp_hop_d   = cnt_q[NODE_W-1:0];
        if (cnt_q < CNT_W'(NODE_COUNT)) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (cmp_v_q && ok_q && v_rdata[cmp_hop_q] && !alu_res[ALU_W-1]) begin
          best_d   = w_rdata;
          chosen_d = cmp_hop_q;
          found_d  = 1'b1;
        end
        if (cnt_q == CNT_W'(NODE_COUNT)) begin
          state_d = ST_PUSH;
        end
      end

      ST_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_hop_d    = chosen_q;
          out_found_d  = found_q;
          out_weight_d = to_out16(best_q);
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      cmp_v_q     <= cmp_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    src_q        <= src_d;
    dst_q        <= dst_d;
    hop_q        <= hop_d;
    rew_q        <= rew_d;
    ok_q         <= ok_d;
    cmp_hop_q    <= cmp_hop_d;
    best_q       <= best_d;
    chosen_q     <= chosen_d;
    found_q      <= found_d;
    out_hop_q    <= out_hop_d;
    out_found_q  <= out_found_d;
    out_weight_q <= out_weight_d;
  end

  assign out_valid_o   = out_valid_q;
  assign chosen_hop_o  = out_hop_q;
  assign found_o       = out_found_q;
  assign best_weight_o = out_weight_q;

  // sequencing checks
  `RWNH_ASSERT_NEXT(a_accept_starts_work, clk_i, rst_ni, in_valid_i && in_ready_o,
    (state_q == ST_UPD_RD) || (state_q == ST_SEL), "accepted beat did not start work")
  `RWNH_ASSERT_NEXT(a_update_one_write, clk_i, rst_ni, state_q == ST_UPD_WR,
    state_q == ST_PUSH, "update wrote for more than one cycle")
  `RWNH_ASSERT_NOW(a_scan_bound, clk_i, rst_ni, state_q == ST_SEL,
    cnt_q <= CNT_W'(NODE_COUNT), "scan counter ran past the last hop")
  `RWNH_ASSERT_NEXT(a_scan_ends, clk_i, rst_ni,
    (state_q == ST_SEL) && (cnt_q == CNT_W'(NODE_COUNT)),
    state_q == ST_PUSH, "scan did not end after the last hop")
  `RWNH_ASSERT_NOW(a_no_found_without_mode, clk_i, rst_ni,
    (state_q == ST_PUSH) && found_q && (mode_q == MODE_UPDATE),
    ok_q, "update reported a write for an out of range entry")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for reward_weighted_next_hop_table
// needs rwnh_pkg and the top level from rtl/core, nothing else
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rwnh_pkg::*;

  localparam int TABLE_N        = NODE_COUNT * NODE_COUNT * NODE_COUNT;
  localparam int PHASE_ITEMS    = 150;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 2 * (NODE_COUNT + 3);
  localparam int QUIET_LIMIT    = 2000;
  localparam int PRINT_CAP      = 100;
  localparam bit CHK_TYPED      = 1'b1;
  localparam bit CHK_PREDICT    = 1'b0;

  // one request beat and one answer beat
  typedef struct packed {
    logic                       mode;
    logic [NODE_W-1:0]          src;
    logic [NODE_W-1:0]          dst;
    logic [NODE_W-1:0]          hop;
    logic signed [REWARD_W-1:0] reward;
  } hop_req_t;

  typedef struct packed {
    logic [NODE_W-1:0]  chosen_hop;
    logic               found;
    logic signed [15:0] best_weight;
  } hop_res_t;

  // directed row: request, then a typed answer where it is obvious
  typedef struct packed {
    logic                       mode;
    logic [NODE_W-1:0]          src;
    logic [NODE_W-1:0]          dst;
    logic [NODE_W-1:0]          hop;
    logic signed [REWARD_W-1:0] reward;
    logic                       typed;
    logic [NODE_W-1:0]          exp_hop;
    logic                       exp_found;
    logic signed [15:0]         exp_weight;
  } dir_row_t;

  localparam int DIR_N = 24;

  dir_row_t dir_rows [DIR_N] = '{
    // empty table answers nothing on both corner pairs
    '{MODE_SELECT, 4'd0,  4'd0,  4'd0,  16'sd0,      CHK_TYPED,   4'd0,  1'b0, 16'sd0},
    '{MODE_SELECT, 4'd15, 4'd15, 4'd15, 16'sh7fff,   CHK_TYPED,   4'd0,  1'b0, 16'sd0},
    // largest reward, fresh then averaged with itself
    '{MODE_UPDATE, 4'd0,  4'd0,  4'd0,  16'sh7fff,   CHK_TYPED,   4'd0,  1'b1, 16'sh7fff},
    '{MODE_UPDATE, 4'd0,  4'd0,  4'd0,  16'sh7fff,   CHK_TYPED,   4'd0,  1'b1, 16'sh7fff},
    '{MODE_UPDATE, 4'd0,  4'd0,  4'd15, 16'sh7fff,   CHK_TYPED,   4'd15, 1'b1, 16'sh7fff},
    // tie on select, the later hop wins
    '{MODE_SELECT, 4'd0,  4'd0,  4'd5,  16'sh1234,   CHK_TYPED,   4'd15, 1'b1, 16'sh7fff},
    // most negative reward, fresh then averaged
    '{MODE_UPDATE, 4'd15, 4'd15, 4'd3,  16'sh8000,   CHK_TYPED,   4'd3,  1'b1, 16'sh8000},
    '{MODE_UPDATE, 4'd15, 4'd15, 4'd3,  16'sh8000,   CHK_TYPED,   4'd3,  1'b1, 16'sh8000},
    // only negative weights: nothing qualifies
    '{MODE_SELECT, 4'd15, 4'd15, 4'd0,  16'sd0,      CHK_TYPED,   4'd0,  1'b0, 16'sd0},
    // halving rounds toward minus infinity
    '{MODE_UPDATE, 4'd15, 4'd15, 4'd7,  -16'sd3,     CHK_TYPED,   4'd7,  1'b1, -16'sd3},
    '{MODE_UPDATE, 4'd15, 4'd15, 4'd7,  16'sd0,      CHK_TYPED,   4'd7,  1'b1, -16'sd2},
    '{MODE_UPDATE, 4'd15, 4'd15, 4'd7,  16'sd1,      CHK_TYPED,   4'd7,  1'b1, -16'sd1},
    // zero weight still qualifies
    '{MODE_UPDATE, 4'd15, 4'd15, 4'd9,  16'sd0,      CHK_TYPED,   4'd9,  1'b1, 16'sd0},
    '{MODE_SELECT, 4'd15, 4'd15, 4'd0,  16'sd0,      CHK_TYPED,   4'd9,  1'b1, 16'sd0},
    '{MODE_UPDATE, 4'd5,  4'd10, 4'd2,  16'sd384,    CHK_TYPED,   4'd2,  1'b1, 16'sd384},
    '{MODE_UPDATE, 4'd5,  4'd10, 4'd2,  -16'sd385,   CHK_TYPED,   4'd2,  1'b1, -16'sd1},
    '{MODE_UPDATE, 4'd5,  4'd10, 4'd1,  16'sd100,    CHK_PREDICT, 4'd0,  1'b0, 16'sd0},
    '{MODE_UPDATE, 4'd5,  4'd10, 4'd4,  16'sd50,     CHK_PREDICT, 4'd0,  1'b0, 16'sd0},
    '{MODE_UPDATE, 4'd5,  4'd10, 4'd4,  16'sd151,    CHK_PREDICT, 4'd0,  1'b0, 16'sd0},
    '{MODE_SELECT, 4'd5,  4'd10, 4'd0,  16'sd0,      CHK_PREDICT, 4'd0,  1'b0, 16'sd0},
    // select ignores hop and reward fields
    '{MODE_SELECT, 4'd10, 4'd5,  4'd15, 16'sh5555,   CHK_TYPED,   4'd0,  1'b0, 16'sd0},
    '{MODE_UPDATE, 4'd10, 4'd5,  4'd10, 16'sh2aaa,   CHK_TYPED,   4'd10, 1'b1, 16'sh2aaa},
    '{MODE_UPDATE, 4'd0,  4'd0,  4'd15, 16'sh8000,   CHK_PREDICT, 4'd0,  1'b0, 16'sd0},
    '{MODE_SELECT, 4'd0,  4'd0,  4'd0,  16'sd0,      CHK_PREDICT, 4'd0,  1'b0, 16'sd0}
  };

  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_ready_o;
  logic                       mode_i       = MODE_UPDATE;
  logic [NODE_W-1:0]          src_node_i   = '0;
  logic [NODE_W-1:0]          dst_node_i   = '0;
  logic [NODE_W-1:0]          next_hop_i   = '0;
  logic signed [REWARD_W-1:0] reward_i     = '0;
  logic                       out_valid_o;
  logic                       out_ready_i  = 1'b0;
  logic [NODE_W-1:0]          chosen_hop_o;
  logic                       found_o;
  logic signed [15:0]         best_weight_o;

  // own copy of the table
  weight_t weight_mdl [TABLE_N];
  bit      valid_mdl  [TABLE_N];

  hop_res_t          awaited_q [$];
  int                mismatches = 0;
  int                results_seen = 0;
  int                gap_pct = 20;
  int                stall_pct = 45;
  bit                hold_req = 1'b0;
  logic [PAIR_W-1:0] hot_pairs [4];

  reward_weighted_next_hop_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .src_node_i    (src_node_i),
    .dst_node_i    (dst_node_i),
    .next_hop_i    (next_hop_i),
    .reward_i      (reward_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .chosen_hop_o  (chosen_hop_o),
    .found_o       (found_o),
    .best_weight_o (best_weight_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // apply one request to the table copy and work out its answer
  function automatic hop_res_t apply_to_table(input hop_req_t r);
    hop_res_t                    res;
    logic [ADDR_W-1:0]           idx;
    logic signed [WEIGHT_BITS:0] sum;
    weight_t                     best;
    res = '0;
    if (r.mode == MODE_UPDATE) begin
      idx = {r.src, r.dst, r.hop};
      if (valid_mdl[idx]) begin
        sum = $signed(weight_mdl[idx]) + $signed(r.reward);
        weight_mdl[idx] = sum[WEIGHT_BITS:1];
      end else begin
        weight_mdl[idx] = r.reward;
      end
      valid_mdl[idx]  = 1'b1;
      res.chosen_hop  = r.hop;
      res.found       = 1'b1;
      res.best_weight = weight_mdl[idx];
    end else begin
      // ascending scan, ties go to the later hop
      best = '0;
      for (int h = 0; h < NODE_COUNT; h++) begin
        idx = {r.src, r.dst, NODE_W'(h)};
        if (valid_mdl[idx] && weight_mdl[idx] >= best) begin
          best           = weight_mdl[idx];
          res.chosen_hop = NODE_W'(h);
          res.found      = 1'b1;
        end
      end
      res.best_weight = best;
    end
    return res;
  endfunction

  // random request, mostly aimed at a few busy pairs
  function automatic hop_req_t random_request();
    hop_req_t r;
    r.mode = ($urandom_range(99) < 30) ? MODE_SELECT : MODE_UPDATE;
    if ($urandom_range(99) < 80) begin
      {r.src, r.dst} = hot_pairs[$urandom_range(3)];
    end else begin
      {r.src, r.dst} = PAIR_W'($urandom);
    end
    r.hop = NODE_W'($urandom);
    case ($urandom_range(7))
      0: r.reward = 16'sh7fff;
      1: r.reward = 16'sh8000;
      2: r.reward = '0;
      3, 4: r.reward = REWARD_W'($urandom_range(511)) - 16'sd256;
      default: r.reward = REWARD_W'($urandom);
    endcase
    return r;
  endfunction

  // offer one beat, record its answer once taken
  task automatic send_request(input hop_req_t req, input bit typed, input hop_res_t typed_res);
    hop_res_t predicted;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= req.mode;
    src_node_i <= req.src;
    dst_node_i <= req.dst;
    next_hop_i <= req.hop;
    reward_i   <= req.reward;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_to_table(req);
    awaited_q = {awaited_q, (typed ? typed_res : predicted)};
    @(negedge clk_i);
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch at result %0d, %s: got %0d, want %0d", results_seen, field, got, want);
    end
    mismatches++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    hop_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_q.size() == 0) begin
        report_mismatch("result with nothing awaited", int'(chosen_hop_o), -1);
      end else begin
        want = awaited_q.pop_front();
        if (chosen_hop_o !== want.chosen_hop)
          report_mismatch("chosen_hop", int'(chosen_hop_o), int'(want.chosen_hop));
        if (found_o !== want.found)
          report_mismatch("found", int'(found_o), int'(want.found));
        if (best_weight_o !== want.best_weight)
          report_mismatch("best_weight", int'(best_weight_o), int'(want.best_weight));
      end
      results_seen++;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // main sequence
  initial begin
    hop_req_t req;
    hop_res_t typed_res;
    int       phase_gap   [3];
    int       phase_stall [3];
    phase_gap   = '{20, 45, 0};
    phase_stall = '{45, 20, 0};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows
    foreach (dir_rows[i]) begin
      req       = '{dir_rows[i].mode, dir_rows[i].src, dir_rows[i].dst,
                    dir_rows[i].hop, dir_rows[i].reward};
      typed_res = '{dir_rows[i].exp_hop, dir_rows[i].exp_found, dir_rows[i].exp_weight};
      send_request(req, dir_rows[i].typed, typed_res);
    end

    // random phases with different idling, long hold-off in the last
    for (int p = 0; p < 3; p++) begin
      gap_pct   = phase_gap[p];
      stall_pct = phase_stall[p];
      foreach (hot_pairs[k]) hot_pairs[k] = PAIR_W'($urandom);
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_request(), CHK_PREDICT, '0);
      end
    end
    in_valid_i <= 1'b0;

    // drain
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/rwnh_pkg.sv
rtl/core/rwnh_alu.sv
rtl/core/rwnh_store.sv
rtl/core/reward_weighted_next_hop_table.sv
tb/testbench.sv
